FILE: design/admg_pkg.sv
package admg_pkg;

    localparam int VERTEX_W         = 4;
    localparam int COUNT_W          = 5;
    localparam int CMD_W            = 2;
    localparam int KIND_W           = 2;
    localparam int DEF_MAX_VERTICES = 16;
    localparam int MAX_RESULTS      = 16;
    localparam int STACK_AW         = $clog2(MAX_RESULTS);
    localparam int STACK_DW         = STACK_AW + 1;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEGREE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DEGREE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

    typedef struct packed {
        logic                clear;
        logic                push;
        logic                pop;
        logic [VERTEX_W-1:0] data;
    } stack_op_t;

endpackage

FILE: design/admg_lowbit.sv
module admg_lowbit #(
    parameter int WIDTH = 16
) (
    input  logic [WIDTH-1:0]         vec,
    output logic                     found,
    output logic [$clog2(WIDTH)-1:0] index
);

    localparam int IW = $clog2(WIDTH);

    always_comb
    begin
        found = |vec;
        index = '0;
        for (int i = WIDTH - 1; i >= 0; i--)
        begin
            if (vec[i])
            begin
                index = IW'(i);
            end
        end
    end

endmodule

FILE: design/admg_stack.sv
module admg_stack
    import admg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  stack_op_t           op,
    output logic [VERTEX_W-1:0] top,
    output logic [STACK_DW-1:0] depth
);

    logic [VERTEX_W-1:0] mem [MAX_RESULTS];
    logic [VERTEX_W-1:0] top_reg;
    logic [STACK_DW-1:0] depth_reg;
    logic [STACK_DW-1:0] depth_next;
    logic [STACK_DW-1:0] base;
    logic [STACK_DW-1:0] under_ptr;

    always_comb
    begin
        base       = op.clear ? '0 : depth_reg;
        depth_next = base;
        if (op.push)
        begin
            depth_next = base + STACK_DW'(1);
        end
        else if (op.pop)
        begin
            depth_next = base - STACK_DW'(1);
        end
        under_ptr = depth_reg - STACK_DW'(2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
        end
        else
        begin
            depth_reg <= depth_next;
        end
    end

    // top is held in a register; a pop fetches the entry below it
    always_ff @(posedge clk)
    begin
        if (op.push)
        begin
            mem[base[STACK_AW-1:0]] <= op.data;
            top_reg                 <= op.data;
        end
        else if (op.pop)
        begin
            top_reg <= mem[under_ptr[STACK_AW-1:0]];
        end
    end

    assign top   = top_reg;
    assign depth = depth_reg;

endmodule

FILE: design/adjacency_matrix_graph_dfs_core.sv
// Undirected graph engine over an adjacency bit matrix (cleared at reset) with
// three commands: insert edge (one acknowledge), degree query (one answer,
// counted over the set bits of the row) and depth-first search (one result
// per visited vertex, preorder, lowest neighbour first, at most 16 results,
// last one flagged). The pace is set by the single lowest-set-bit encoder
// shared by the degree count and the neighbour pick, which handles one step
// per cycle, except that a search step that emits a result waits while the
// output register is stalled. A new transaction is taken once the previous
// one has placed its final result in the output register; a stalled output
// holds the sequencer.
module adjacency_matrix_graph_dfs_core
    import admg_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write_en,
    input  logic [COUNT_W-1:0]  cfg_write_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [CMD_W-1:0]    cmd,
    input  logic [VERTEX_W-1:0] first_vertex,
    input  logic [VERTEX_W-1:0] second_vertex,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [KIND_W-1:0]   kind,
    output logic [VERTEX_W-1:0] vertex,
    output logic [COUNT_W-1:0]  degree_count,
    output logic                edge_accepted,
    output logic                last
);

    localparam int ROWS = (MAX_VERTICES < (1 << VERTEX_W)) ? MAX_VERTICES : (1 << VERTEX_W);
    localparam int IW   = $clog2(ROWS);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_INSERT  = 3'd1;
    localparam logic [2:0] ST_INSERT2 = 3'd2;
    localparam logic [2:0] ST_DEGREE  = 3'd3;
    localparam logic [2:0] ST_SEARCH  = 3'd4;
    localparam logic [2:0] ST_FLUSH   = 3'd5;
    localparam logic [2:0] ST_DEG_LD  = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [COUNT_W-1:0]  vcount_reg;
    logic [VERTEX_W-1:0] a_reg, a_next;
    logic [VERTEX_W-1:0] b_reg, b_next;
    logic [ROWS-1:0]     adj_reg [ROWS];
    logic [ROWS-1:0]     visited_reg, visited_next;
    logic [ROWS-1:0]     work_reg, work_next;
    logic [COUNT_W-1:0]  cnt_reg, cnt_next;
    logic [VERTEX_W-1:0] pend_reg, pend_next;

    logic                out_valid_reg;
    logic [KIND_W-1:0]   kind_reg;
    logic [VERTEX_W-1:0] vertex_reg;
    logic [COUNT_W-1:0]  degree_count_reg;
    logic                edge_accepted_reg;
    logic                last_reg;

    logic                out_free;
    logic                out_load;
    logic [KIND_W-1:0]   ld_kind;
    logic [VERTEX_W-1:0] ld_vertex;
    logic [COUNT_W-1:0]  ld_degree;
    logic                ld_accepted;
    logic                ld_last;

    logic                wr_en;
    logic [IW-1:0]       wr_row;
    logic [IW-1:0]       wr_col;

    logic [ROWS-1:0]     used_mask;
    logic [VERTEX_W-1:0] rd_vertex;
    logic [ROWS-1:0]     rd_row;
    logic [ROWS-1:0]     cand;
    logic [ROWS-1:0]     enc_in;
    logic                enc_found;
    logic [IW-1:0]       enc_index;
    logic                ins_ok;

    stack_op_t           stk_op;
    logic [VERTEX_W-1:0] stk_top;
    logic [STACK_DW-1:0] stk_depth;

    admg_lowbit #(
        .WIDTH (ROWS)
    ) u_lowbit (
        .vec   (enc_in),
        .found (enc_found),
        .index (enc_index)
    );

    admg_stack u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (stk_op),
        .top   (stk_top),
        .depth (stk_depth)
    );

    always_comb
    begin
        for (int i = 0; i < ROWS; i++)
        begin
            used_mask[i] = COUNT_W'(i) < vcount_reg;
        end
        rd_vertex = (state_reg == ST_SEARCH) ? stk_top : b_reg;
        rd_row    = ({1'b0, rd_vertex} < COUNT_W'(ROWS)) ? adj_reg[rd_vertex[IW-1:0]] : '0;
        cand      = rd_row & used_mask & ~visited_reg;
        enc_in    = (state_reg == ST_DEGREE) ? work_reg : cand;
        ins_ok    = ({1'b0, a_reg} < vcount_reg) && ({1'b0, b_reg} < vcount_reg)
                    && ({1'b0, a_reg} < COUNT_W'(ROWS)) && ({1'b0, b_reg} < COUNT_W'(ROWS));
        out_free  = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        state_next   = state_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        visited_next = visited_reg;
        work_next    = work_reg;
        cnt_next     = cnt_reg;
        pend_next    = pend_reg;
        out_load     = 1'b0;
        ld_kind      = KIND_SEARCH;
        ld_vertex    = pend_reg;
        ld_degree    = '0;
        ld_accepted  = 1'b0;
        ld_last      = 1'b0;
        wr_en        = 1'b0;
        wr_row       = a_reg[IW-1:0];
        wr_col       = b_reg[IW-1:0];
        stk_op       = '0;
        in_ready     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    a_next = first_vertex;
                    b_next = second_vertex;
                    case (cmd)
                        CMD_INSERT:
                        begin
                            state_next = ST_INSERT;
                        end
                        CMD_DEGREE:
                        begin
                            state_next = ST_DEG_LD;
                        end
                        CMD_SEARCH:
                        begin
                            visited_next = '0;
                            if ({1'b0, first_vertex} < COUNT_W'(ROWS))
                            begin
                                visited_next = ROWS'(1) << first_vertex[IW-1:0];
                            end
                            pend_next   = first_vertex;
                            cnt_next    = COUNT_W'(1);
                            stk_op.clear = 1'b1;
                            stk_op.push  = 1'b1;
                            stk_op.data  = first_vertex;
                            state_next   = ST_SEARCH;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_INSERT:
            begin
                wr_en      = ins_ok;
                state_next = ST_INSERT2;
            end
            ST_INSERT2:
            begin
                wr_row      = b_reg[IW-1:0];
                wr_col      = a_reg[IW-1:0];
                ld_kind     = KIND_INSERT;
                ld_vertex   = '0;
                ld_accepted = ins_ok;
                ld_last     = 1'b1;
                if (out_free)
                begin
                    wr_en      = ins_ok;
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DEG_LD:
            begin
                work_next  = rd_row & used_mask;
                cnt_next   = '0;
                state_next = ST_DEGREE;
            end
            ST_DEGREE:
            begin
                ld_kind   = KIND_DEGREE;
                ld_vertex = b_reg;
                ld_degree = cnt_reg;
                ld_last   = 1'b1;
                if (enc_found)
                begin
                    work_next = work_reg & ~(ROWS'(1) << enc_index);
                    cnt_next  = cnt_reg + COUNT_W'(1);
                end
                else if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SEARCH:
            begin
                if (stk_depth == '0)
                begin
                    state_next = ST_FLUSH;
                end
                else if (!enc_found)
                begin
                    stk_op.pop = 1'b1;
                end
                else if (out_free)
                begin
                    out_load     = 1'b1;
                    pend_next    = VERTEX_W'(enc_index);
                    visited_next = visited_reg | (ROWS'(1) << enc_index);
                    stk_op.push  = 1'b1;
                    stk_op.data  = VERTEX_W'(enc_index);
                    cnt_next     = cnt_reg + COUNT_W'(1);
                    if (cnt_reg == COUNT_W'(MAX_RESULTS - 1))
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                ld_last = 1'b1;
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            vcount_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int r = 0; r < ROWS; r++)
            begin
                adj_reg[r] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_load || (out_valid_reg && !out_ready);
            if (cfg_write_en)
            begin
                vcount_reg <= cfg_write_data;
            end
            if (wr_en)
            begin
                adj_reg[wr_row][wr_col] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg       <= a_next;
        b_reg       <= b_next;
        visited_reg <= visited_next;
        work_reg    <= work_next;
        cnt_reg     <= cnt_next;
        pend_reg    <= pend_next;
        if (out_load)
        begin
            kind_reg          <= ld_kind;
            vertex_reg        <= ld_vertex;
            degree_count_reg  <= ld_degree;
            edge_accepted_reg <= ld_accepted;
            last_reg          <= ld_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign vertex        = vertex_reg;
    assign degree_count  = degree_count_reg;
    assign edge_accepted = edge_accepted_reg;
    assign last          = last_reg;

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n)
        stk_depth <= STACK_DW'(MAX_RESULTS))
        else $error("search stack overrun");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> (cnt_reg >= COUNT_W'(1)
            && cnt_reg < COUNT_W'(MAX_RESULTS)))
        else $error("search result count out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DEGREE) |-> (cnt_reg <= COUNT_W'(ROWS)))
        else $error("degree count exceeds row width");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && cmd == CMD_SEARCH) |=> (state_reg == ST_SEARCH
            && stk_depth == STACK_DW'(1)))
        else $error("search did not start with one stacked vertex");
`endif

endmodule

FILE: tb/tb_adjacency_matrix_graph_dfs_core.sv
`timescale 1ns / 1ps

module tb_adjacency_matrix_graph_dfs_core;
    import admg_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 64;
    localparam int LONG_HOLD    = 400;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [VERTEX_W-1:0] vertex;
        logic [COUNT_W-1:0]  degree;
        logic                accepted;
        logic                last;
    } graph_result_t;

    class graph_scoreboard;
        logic [15:0]   adj_rows [16];
        logic [4:0]    vertex_limit;
        graph_result_t pending [$];
        int            mismatches;

        function new();
            foreach (adj_rows[i])
                adj_rows[i] = '0;
            vertex_limit = '0;
            mismatches = 0;
        endfunction

        function void set_vertex_count(logic [4:0] value);
            vertex_limit = value;
        endfunction

        function void note_command(logic [CMD_W-1:0] op, logic [3:0] va, logic [3:0] vb);
            int            n;
            logic [16:0]   wide;
            logic [15:0]   mask;
            logic [15:0]   visited;
            logic [15:0]   cand;
            logic [3:0]    path [16];
            int            depth;
            int            emitted;
            int            pick;
            graph_result_t res [16];
            n = (vertex_limit > 16) ? 16 : int'(vertex_limit);
            wide = (17'd1 << n) - 17'd1;
            mask = wide[15:0];
            emitted = 0;
            for (int i = 0; i < 16; i++)
                res[i] = '0;
            case (op)
                CMD_INSERT:
                begin
                    res[0].kind = KIND_INSERT;
                    res[0].accepted = (int'(va) < n) && (int'(vb) < n);
                    if (res[0].accepted)
                    begin
                        adj_rows[va][vb] = 1'b1;
                        adj_rows[vb][va] = 1'b1;
                    end
                    emitted = 1;
                end
                CMD_DEGREE:
                begin
                    res[0].kind = KIND_DEGREE;
                    res[0].vertex = vb;
                    res[0].degree = COUNT_W'($countones(adj_rows[vb] & mask));
                    emitted = 1;
                end
                CMD_SEARCH:
                begin
                    visited = 16'd1 << va;
                    res[0].kind = KIND_SEARCH;
                    res[0].vertex = va;
                    emitted = 1;
                    path[0] = va;
                    depth = 1;
                    while (depth > 0 && emitted < MAX_RESULTS)
                    begin
                        cand = adj_rows[path[depth-1]] & mask & ~visited;
                        if (cand == '0)
                            depth--;
                        else
                        begin
                            pick = 0;
                            for (int i = 15; i >= 0; i--)
                                if (cand[i])
                                    pick = i;
                            visited[pick] = 1'b1;
                            res[emitted].kind = KIND_SEARCH;
                            res[emitted].vertex = VERTEX_W'(pick);
                            emitted++;
                            if (depth < 16)
                            begin
                                path[depth] = VERTEX_W'(pick);
                                depth++;
                            end
                        end
                    end
                end
                default:
                    emitted = 0;
            endcase
            if (emitted > 0)
                res[emitted-1].last = 1'b1;
            for (int i = 0; i < emitted; i++)
                pending.push_back(res[i]);
        endfunction

        function void check_result(graph_result_t got);
            graph_result_t exp_res;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected kind=%0d vertex=%0d deg=%0d acc=%0b last=%0b",
                             $realtime, got.kind, got.vertex, got.degree, got.accepted,
                             got.last);
                return;
            end
            exp_res = pending.pop_front();
            if (got.kind !== exp_res.kind || got.vertex !== exp_res.vertex
                || got.degree !== exp_res.degree || got.accepted !== exp_res.accepted
                || got.last !== exp_res.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch exp kind=%0d vertex=%0d deg=%0d acc=%0b last=%0b",
                             $realtime, exp_res.kind, exp_res.vertex, exp_res.degree,
                             exp_res.accepted, exp_res.last,
                             " | got kind=%0d vertex=%0d deg=%0d acc=%0b last=%0b",
                             got.kind, got.vertex, got.degree, got.accepted, got.last);
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                cfg_write_en;
    logic [COUNT_W-1:0]  cfg_write_data;
    logic                in_valid;
    logic                in_ready;
    logic [CMD_W-1:0]    cmd;
    logic [VERTEX_W-1:0] first_vertex;
    logic [VERTEX_W-1:0] second_vertex;
    logic                out_valid;
    logic                out_ready;
    logic [KIND_W-1:0]   kind;
    logic [VERTEX_W-1:0] vertex;
    logic [COUNT_W-1:0]  degree_count;
    logic                edge_accepted;
    logic                last;

    graph_scoreboard sb;
    int              sender_idle_pct;
    int              receiver_stall_pct;
    int              hold_left;
    int              cur_vertex_count;

    adjacency_matrix_graph_dfs_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .first_vertex   (first_vertex),
        .second_vertex  (second_vertex),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .vertex         (vertex),
        .degree_count   (degree_count),
        .edge_accepted  (edge_accepted),
        .last           (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // receiver: random stalls plus an occasional long hold-off
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge clk)
    begin : monitor
        graph_result_t got;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got.kind = kind;
                got.vertex = vertex;
                got.degree = degree_count;
                got.accepted = edge_accepted;
                got.last = last;
                sb.check_result(got);
            end
            if (in_valid && in_ready)
                sb.note_command(cmd, first_vertex, second_vertex);
        end
    end

    task automatic send_command(logic [CMD_W-1:0] op, logic [3:0] va, logic [3:0] vb);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd <= op;
        first_vertex <= va;
        second_vertex <= vb;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_vertex_count(logic [4:0] value);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_write_data <= value;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        sb.set_vertex_count(value);
        cur_vertex_count = (value > 16) ? 16 : int'(value);
    endtask

    function automatic logic [3:0] pick_vertex();
        if (cur_vertex_count > 0 && $urandom_range(99) < 80)
            return 4'($urandom_range(cur_vertex_count - 1));
        return 4'($urandom_range(15));
    endfunction

    task automatic random_command();
        int          roll;
        logic [CMD_W-1:0] op;
        roll = $urandom_range(99);
        if (roll < 50)
            op = CMD_INSERT;
        else if (roll < 68)
            op = CMD_DEGREE;
        else if (roll < 95)
            op = CMD_SEARCH;
        else
            op = CMD_UNUSED;
        send_command(op, pick_vertex(), pick_vertex());
    endtask

    task automatic run_phase(logic [4:0] count, int idle_pct, int stall_pct, int items,
                             bit pressure);
        write_vertex_count(count);
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int i = 0; i < items; i++)
        begin
            if (pressure && i == 4)
                hold_left = LONG_HOLD;
            random_command();
        end
        drain_results();
    endtask

    initial
    begin
        sb = new();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_left = 0;
        cur_vertex_count = 0;
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_write_data = '0;
        in_valid = 1'b0;
        cmd = CMD_INSERT;
        first_vertex = '0;
        second_vertex = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // full capacity: path 0..15 gives a maximal search
        write_vertex_count(5'd16);
        for (int i = 0; i < 15; i++)
            send_command(CMD_INSERT, 4'(i), 4'(i + 1));
        send_command(CMD_INSERT, 4'd3, 4'd3);
        send_command(CMD_DEGREE, 4'd0, 4'd3);
        send_command(CMD_DEGREE, 4'd15, 4'd15);
        send_command(CMD_SEARCH, 4'd0, 4'd0);
        send_command(CMD_UNUSED, 4'd15, 4'd15);
        drain_results();

        // few vertices in use: rejected inserts, unused start and degree
        write_vertex_count(5'd4);
        send_command(CMD_INSERT, 4'd5, 4'd1);
        send_command(CMD_INSERT, 4'd15, 4'd15);
        send_command(CMD_INSERT, 4'd1, 4'd3);
        send_command(CMD_DEGREE, 4'd0, 4'd14);
        send_command(CMD_SEARCH, 4'd15, 4'd0);
        send_command(CMD_SEARCH, 4'd3, 4'd0);
        drain_results();

        run_phase(5'd16, 0, 0, 34, 1'b0);
        run_phase(5'd7, 64, 0, 30, 1'b0);
        run_phase(5'd31, 0, 64, 30, 1'b1);
        run_phase(5'd0, 34, 34, 12, 1'b0);
        run_phase(5'd11, 34, 34, 26, 1'b0);
        run_phase(5'd2, 0, 0, 12, 1'b0);

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
